// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Textured column scaler package
// Shared field widths, function codes, register indexes and the item
// structures that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 8;
    localparam int HALF_W   = 12;
    localparam int HGT_W    = 13;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 10;
    localparam int VH_W     = 10;
    localparam int PW_W     = 5;
    localparam int PIX_W    = 8;
    localparam int FRAC_W   = 16;

    localparam int SHADE_ENTRIES = 256;
    localparam int SHADE_AW      = 8;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_LOAD_TEXEL = 2'd0;
    localparam t_func FUNC_LOAD_SHADE = 2'd1;
    localparam t_func FUNC_DRAW       = 2'd2;

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 10;

    typedef logic [CFG_AW-1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_VIEW_HEIGHT = 1'b0;
    localparam t_cfg_addr CFG_POST_WIDTH  = 1'b1;

    localparam logic [VH_W-1:0] VIEW_HEIGHT_RST = 10'd200;
    localparam logic [PW_W-1:0] POST_WIDTH_RST  = 5'd1;

    // Item as it enters the pipeline, post height already doubled.
    typedef struct packed {
        t_func              func;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   val;
        logic [HGT_W-1:0]   height;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               lit;
    } t_item;

    // Item after clipping: height is no longer needed, top row and fault are.
    typedef struct packed {
        t_func              func;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   val;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [VH_W-1:0]    top;
        logic               lit;
        logic               fault;
    } t_ctl;

endpackage

// ===== rtl/tcs_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step divider
// Pipelined restoring divider forming (TEXEL_COUNT << 16) / height, one
// quotient bit per stage, with the item carried alongside.
// ----------------------------------------------------------------------------
module tcs_divider #(
    parameter int TEXEL_COUNT = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  tcs_pkg::t_item         i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output tcs_pkg::t_item         o_item,
    output logic [$clog2(TEXEL_COUNT+1)+tcs_pkg::FRAC_W-1:0] o_quot
);

    localparam int DW = $clog2(TEXEL_COUNT + 1) + tcs_pkg::FRAC_W;
    localparam int HW = tcs_pkg::HGT_W;
    localparam logic [DW-1:0] DIVIDEND = DW'(TEXEL_COUNT) << tcs_pkg::FRAC_W;

    logic [DW-1:0]   r_v;
    logic [DW:0]     en;
    tcs_pkg::t_item  r_item [DW];
    logic [HW-1:0]   r_rem  [DW];
    logic [DW-1:0]   r_q    [DW];

    assign en[DW] = i_ready;

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic            v_in;
        tcs_pkg::t_item  item_in;
        logic [HW-1:0]   rem_in;
        logic [DW-1:0]   q_in;
        logic [HW:0]     trial;
        logic            fit;
        logic [HW-1:0]   n_rem;
        logic [DW-1:0]   n_q;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign item_in = i_item;
            assign rem_in  = '0;
            assign q_in    = '0;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign item_in = r_item[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
        end

        assign en[k] = !r_v[k] || en[k+1];

        always_comb begin
            trial = {rem_in, DIVIDEND[DW-1-k]};
            fit   = trial >= {1'b0, item_in.height};
            n_rem = fit ? HW'(trial - {1'b0, item_in.height}) : trial[HW-1:0];
            n_q   = {q_in[DW-2:0], fit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_item[k] <= item_in;
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[DW-1];
    assign o_item  = r_item[DW-1];
    assign o_quot  = r_q[DW-1];

    localparam int PW = DW + HW;

    a_quot_exact : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.height != '0) |->
            ((PW'(o_quot) * PW'(o_item.height)) <= PW'(DIVIDEND)) &&
            ((PW'(DIVIDEND) - PW'(o_quot) * PW'(o_item.height)) < PW'(o_item.height)))
        else $error("step quotient does not match dividend and height");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quot) && $stable(o_item))
        else $error("divider output changed while stalled");

endmodule

// ===== rtl/tcs_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel coordinate mapper
// Clips the post to the viewport, then forms the texel index
// (start + row * step) >> 16 over three register stages.
// ----------------------------------------------------------------------------
module tcs_mapper #(
    parameter int TEXEL_COUNT = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [tcs_pkg::VH_W-1:0]               i_view_height,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  tcs_pkg::t_item                         i_item,
    input  logic [$clog2(TEXEL_COUNT+1)+tcs_pkg::FRAC_W-1:0] i_step,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output tcs_pkg::t_ctl                          o_ctl,
    output logic [$clog2(TEXEL_COUNT)-1:0]         o_addr
);

    localparam int DW  = $clog2(TEXEL_COUNT + 1) + tcs_pkg::FRAC_W;
    localparam int AW  = $clog2(TEXEL_COUNT);
    localparam int HW  = tcs_pkg::HGT_W;
    localparam int FW  = DW + tcs_pkg::HALF_W;
    localparam int RW  = DW + tcs_pkg::ROW_W;
    localparam int SW  = FW + 1;
    localparam int TW  = SW - tcs_pkg::FRAC_W;
    localparam logic [TW-1:0] TEX_LIMIT = TW'(TEXEL_COUNT);
    localparam logic [AW-1:0] TEX_LAST  = AW'(TEXEL_COUNT - 1);

    logic en_a, en_b, en_c;

    // Stage A: clip against the viewport.
    logic                            r_a_v;
    tcs_pkg::t_ctl                   r_a_ctl;
    logic [DW-1:0]                   r_a_step;
    logic [tcs_pkg::HALF_W-1:0]      r_a_half;

    logic [HW-1:0]                   vh_ext;
    logic                            over;
    logic [HW-1:0]                   diff;
    logic [HW-1:0]                   drawn;
    tcs_pkg::t_ctl                   n_a_ctl;
    logic [tcs_pkg::HALF_W-1:0]      n_a_half;

    always_comb begin
        vh_ext   = HW'(i_view_height);
        over     = i_item.height > vh_ext;
        diff     = over ? (i_item.height - vh_ext) : (vh_ext - i_item.height);
        drawn    = over ? vh_ext : i_item.height;
        n_a_half = over ? diff[HW-1:1] : '0;

        n_a_ctl.func  = i_item.func;
        n_a_ctl.idx   = i_item.idx;
        n_a_ctl.val   = i_item.val;
        n_a_ctl.col   = i_item.col;
        n_a_ctl.row   = i_item.row;
        n_a_ctl.lit   = i_item.lit;
        // Below the viewport height the difference is at most ten bits wide.
        n_a_ctl.top   = over ? '0 : diff[tcs_pkg::VH_W:1];
        n_a_ctl.fault = (i_item.height == '0) || (HW'(i_item.row) >= drawn);
    end

    // Stage B: the two products.
    logic                            r_b_v;
    tcs_pkg::t_ctl                   r_b_ctl;
    logic [FW-1:0]                   r_b_frac;
    logic [RW-1:0]                   r_b_prod;

    // Stage C: sum, shift and saturate to the store.
    logic                            r_c_v;
    tcs_pkg::t_ctl                   r_c_ctl;
    logic [AW-1:0]                   r_c_addr;

    logic [SW-1:0]                   n_sum;
    logic [TW-1:0]                   n_tex;
    logic [AW-1:0]                   n_addr;

    always_comb begin
        n_sum  = SW'(r_b_frac) + SW'(r_b_prod);
        n_tex  = n_sum[SW-1:tcs_pkg::FRAC_W];
        n_addr = (n_tex >= TEX_LIMIT) ? TEX_LAST : n_tex[AW-1:0];
    end

    assign en_c    = !r_c_v || i_ready;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_ctl  <= n_a_ctl;
            r_a_step <= i_step;
            r_a_half <= n_a_half;
        end
        if (en_b) begin
            r_b_ctl  <= r_a_ctl;
            r_b_frac <= FW'(r_a_half) * FW'(r_a_step);
            r_b_prod <= RW'(r_a_ctl.row) * RW'(r_a_step);
        end
        if (en_c) begin
            r_c_ctl  <= r_b_ctl;
            r_c_addr <= n_addr;
        end
    end

    assign o_valid = r_c_v;
    assign o_ctl   = r_c_ctl;
    assign o_addr  = r_c_addr;

    a_full_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_a_v && r_b_v && r_c_v && !i_ready)
        else $error("mapper refused input with a free stage");

endmodule

// ===== rtl/tcs_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel sampler
// Holds the texel column and shading table, applies loads in stream order,
// reads texel and shade for draws and registers the result transaction.
// ----------------------------------------------------------------------------
module tcs_sampler #(
    parameter int TEXEL_COUNT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [tcs_pkg::PW_W-1:0]          i_post_width,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  tcs_pkg::t_ctl                     i_ctl,
    input  logic [$clog2(TEXEL_COUNT)-1:0]    i_addr,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tcs_pkg::PIX_W-1:0]         o_pixel,
    output logic [tcs_pkg::ROW_W-1:0]         o_screen_row,
    output logic [tcs_pkg::COL_W-1:0]         o_screen_column,
    output logic [tcs_pkg::PW_W-1:0]          o_span_width,
    output logic                              o_fault
);

    localparam int AW = $clog2(TEXEL_COUNT);
    localparam logic [tcs_pkg::IDX_W:0] IDX_LIMIT = (tcs_pkg::IDX_W + 1)'(TEXEL_COUNT);

    function automatic logic [tcs_pkg::PW_W-1:0] width_sat(
        input logic [tcs_pkg::PW_W-1:0] w
    );
        if (w == '0) begin
            return tcs_pkg::PW_W'(1);
        end else if (w > tcs_pkg::PW_W'(16)) begin
            return tcs_pkg::PW_W'(16);
        end
        return w;
    endfunction

    logic [tcs_pkg::VAL_W-1:0] r_texel_mem [TEXEL_COUNT];
    logic [tcs_pkg::PIX_W-1:0] r_shade_mem [tcs_pkg::SHADE_ENTRIES];

    logic en_d, en_e, en_f;

    logic                       r_d_v;
    tcs_pkg::t_ctl              r_d_ctl;
    logic [tcs_pkg::VAL_W-1:0]  r_tex_rd;

    logic                       r_e_v;
    tcs_pkg::t_ctl              r_e_ctl;
    logic [tcs_pkg::VAL_W-1:0]  r_e_tex;
    logic [tcs_pkg::PIX_W-1:0]  r_shade_rd;

    logic                       r_out_v;
    logic [tcs_pkg::PIX_W-1:0]  r_pixel;
    logic [tcs_pkg::ROW_W-1:0]  r_screen_row;
    logic [tcs_pkg::COL_W-1:0]  r_screen_column;
    logic [tcs_pkg::PW_W-1:0]   r_span_width;
    logic                       r_fault;

    logic                       tex_wr;
    logic [tcs_pkg::PIX_W-1:0]  n_pixel;
    logic [tcs_pkg::ROW_W-1:0]  n_screen_row;
    logic [tcs_pkg::COL_W-1:0]  n_screen_column;
    logic [tcs_pkg::PW_W-1:0]   n_span_width;

    // Only draws produce a transaction; loads and unused codes drop out here.
    assign en_f    = !r_out_v || i_ready;
    assign en_e    = !r_e_v || en_f;
    assign en_d    = !r_d_v || en_e;
    assign o_ready = en_d;

    assign tex_wr = i_valid && (i_ctl.func == tcs_pkg::FUNC_LOAD_TEXEL) &&
                    ({1'b0, i_ctl.idx} < IDX_LIMIT);

    always_comb begin
        if (r_e_ctl.fault) begin
            n_pixel         = '0;
            n_screen_row    = '0;
            n_screen_column = '0;
            n_span_width    = '0;
        end else begin
            n_pixel         = r_e_ctl.lit ? r_shade_rd : r_e_tex;
            n_screen_row    = r_e_ctl.top + r_e_ctl.row;
            n_screen_column = r_e_ctl.col;
            n_span_width    = width_sat(i_post_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en_d) begin
                r_d_v <= i_valid;
            end
            if (en_e) begin
                r_e_v <= r_d_v;
            end
            if (en_f) begin
                r_out_v <= r_e_v && (r_e_ctl.func == tcs_pkg::FUNC_DRAW);
            end
        end
    end

    // Each store is written in the same stage where draws read it, so loads
    // and draws see each other in stream order.
    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_ctl  <= i_ctl;
            r_tex_rd <= r_texel_mem[i_addr];
            if (tex_wr) begin
                r_texel_mem[i_ctl.idx[AW-1:0]] <= i_ctl.val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_ctl    <= r_d_ctl;
            r_e_tex    <= r_tex_rd;
            r_shade_rd <= r_shade_mem[r_tex_rd];
            if (r_d_v && (r_d_ctl.func == tcs_pkg::FUNC_LOAD_SHADE)) begin
                r_shade_mem[r_d_ctl.idx] <= r_d_ctl.val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_pixel         <= n_pixel;
            r_screen_row    <= n_screen_row;
            r_screen_column <= n_screen_column;
            r_span_width    <= n_span_width;
            r_fault         <= r_e_ctl.fault;
        end
    end

    assign o_valid         = r_out_v;
    assign o_pixel         = r_pixel;
    assign o_screen_row    = r_screen_row;
    assign o_screen_column = r_screen_column;
    assign o_span_width    = r_span_width;
    assign o_fault         = r_fault;

    a_full_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_d_v && r_e_v && r_out_v && !i_ready)
        else $error("sampler refused input with a free stage");

    a_width_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_fault |-> (o_span_width != '0) &&
                                (o_span_width <= tcs_pkg::PW_W'(16)))
        else $error("span width of a good pixel out of range");

endmodule

// ===== rtl/textured_column_scaler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Textured column scaler
// Samples one scaled, vertically centered wall column pixel per draw
// transaction; load transactions fill the texel column and shading table.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock unless back-pressure from the
// output stream stalls it, and each transaction passes through its stages
// in order: the step divider takes one stage per quotient bit,
// then three stages clip and form the texel index with two multipliers,
// and three more read the texel store, the shading table and register the
// result. Loads travel the same pipeline and take effect in stream order,
// so a draw sees every load accepted before it. Loads and unused function
// codes produce no output transaction. Stores power up undefined; reading
// a texel or shade entry that was never loaded gives an undefined pixel.
// Configuration writes are to be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module textured_column_scaler_top #(
    parameter int TEXEL_COUNT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  tcs_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [tcs_pkg::CFG_DW-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] table_index, [15:8] table_value, [27:16] post_half_height,
    // [37:28] column, [47:38] span_row, [48] lit, [55:49] zero
    input  logic [55:0]                    i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                     i_s_axis_tuser,
    // Output stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] pixel, [17:8] screen_row, [27:18] screen_column,
    // [32:28] span_width, [39:33] zero
    output logic [39:0]                    o_m_axis_tdata,
    // [0] fault
    output logic                           o_m_axis_tuser
);

    localparam int DW = $clog2(TEXEL_COUNT + 1) + tcs_pkg::FRAC_W;
    localparam int AW = $clog2(TEXEL_COUNT);

    logic [tcs_pkg::VH_W-1:0] r_view_height;
    logic [tcs_pkg::PW_W-1:0] r_post_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_height <= tcs_pkg::VIEW_HEIGHT_RST;
            r_post_width  <= tcs_pkg::POST_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tcs_pkg::CFG_VIEW_HEIGHT: begin
                    r_view_height <= i_cfg_wdata;
                end
                tcs_pkg::CFG_POST_WIDTH: begin
                    r_post_width <= i_cfg_wdata[tcs_pkg::PW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tcs_pkg::t_item s_item;

    always_comb begin
        s_item.func   = i_s_axis_tuser;
        s_item.idx    = i_s_axis_tdata[7:0];
        s_item.val    = i_s_axis_tdata[15:8];
        s_item.height = {i_s_axis_tdata[27:16], 1'b0};
        s_item.col    = i_s_axis_tdata[37:28];
        s_item.row    = i_s_axis_tdata[47:38];
        s_item.lit    = i_s_axis_tdata[48];
    end

    logic              div_valid;
    logic              div_ready;
    tcs_pkg::t_item    div_item;
    logic [DW-1:0]     div_quot;

    tcs_divider #(
        .TEXEL_COUNT (TEXEL_COUNT)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (s_item),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_item  (div_item),
        .o_quot  (div_quot)
    );

    logic              map_valid;
    logic              map_ready;
    tcs_pkg::t_ctl     map_ctl;
    logic [AW-1:0]     map_addr;

    tcs_mapper #(
        .TEXEL_COUNT (TEXEL_COUNT)
    ) u_mapper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_view_height (r_view_height),
        .i_valid       (div_valid),
        .o_ready       (div_ready),
        .i_item        (div_item),
        .i_step        (div_quot),
        .o_valid       (map_valid),
        .i_ready       (map_ready),
        .o_ctl         (map_ctl),
        .o_addr        (map_addr)
    );

    logic [tcs_pkg::PIX_W-1:0] out_pixel;
    logic [tcs_pkg::ROW_W-1:0] out_screen_row;
    logic [tcs_pkg::COL_W-1:0] out_screen_column;
    logic [tcs_pkg::PW_W-1:0]  out_span_width;

    tcs_sampler #(
        .TEXEL_COUNT (TEXEL_COUNT)
    ) u_sampler (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_post_width    (r_post_width),
        .i_valid         (map_valid),
        .o_ready         (map_ready),
        .i_ctl           (map_ctl),
        .i_addr          (map_addr),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_pixel         (out_pixel),
        .o_screen_row    (out_screen_row),
        .o_screen_column (out_screen_column),
        .o_span_width    (out_span_width),
        .o_fault         (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {7'd0, out_span_width, out_screen_column,
                             out_screen_row, out_pixel};

endmodule
